@@ design/taylor_sine_cosine_core_defines.svh @@
// Assertion macros used by the Taylor sine and cosine core top level.
`ifndef TAYLOR_SINE_COSINE_CORE_DEFINES_SVH
`define TAYLOR_SINE_COSINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("Assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`endif

@@ design/tsc_pkg.sv @@
// Package with the widths, sequencer states and divisor function of the sine and cosine core.
package tsc_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int ITER_W     = $clog2(MAX_TERMS);

    localparam int FRAC_W     = 30;
    localparam int ANGLE_W    = 31;
    localparam int VALUE_W    = 31;
    localparam int TERMS_W    = 5;
    localparam int CNT_W      = (ITER_W + 1 > TERMS_W) ? ITER_W + 1 : TERMS_W;

    localparam int MAG_W      = 32;
    localparam int X2_W       = 32;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 16;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 64;
    localparam int PROD_W     = 33;
    localparam int SUM_W      = MAG_W + ITER_W + 1;

    localparam int DIV_W      = $clog2((2 * MAX_TERMS) * (2 * MAX_TERMS + 1) + 1);
    localparam int REM_W      = DIV_W + 1;
    localparam int DIGIT_BITS = 8;
    localparam int DIV_STEPS  = (PROD_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int DIV_BITS   = DIV_STEPS * DIGIT_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int S_TDATA_W  = ((ANGLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((VALUE_W + TERMS_W + 7) / 8) * 8;

    localparam logic [VALUE_W-1:0] ONE_Q30 = VALUE_W'(1) << FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_LO,
        ST_SQ_HI,
        ST_X2,
        ST_TERM,
        ST_MUL_HI,
        ST_DIV,
        ST_FIN
    } state_t;

    // Divisor that turns the current term into the next one.
    function automatic logic [DIV_W-1:0] divisor_for(input logic [ITER_W-1:0] iter,
                                                     input logic want_cos);
        int n;
        int d;
        n = 2 * int'(iter) + 1;
        d = want_cos ? n * (n + 1) : (n + 1) * (n + 2);
        return DIV_W'(d);
    endfunction

endpackage

@@ design/taylor_sine_cosine_core.sv @@
// Top level of the fixed-point Taylor series sine and cosine core.
//
// A request arrives on the s_ channel: s_tdata[30:0] holds the angle in unsigned
// Q1.30 radians and s_tuser[0] selects sine (0) or cosine (1). The result leaves on
// the m_ channel: m_tdata[30:0] holds the value in Q1.30, clamped to zero through one,
// and m_tdata[35:31] holds the iteration count, which is the number of terms added
// plus one.
// One request is worked on at a time and s_tready is high only while the core is idle.
// The angle is squared in the states ST_SQ_LO, ST_SQ_HI and ST_X2. Each series term then uses
// the shared 32 by 16 bit multiplier in ST_TERM and ST_MUL_HI and the divider in ST_DIV,
// which retires eight quotient bits a cycle.
// The result sits in an output register, so a new request is accepted while it waits.
// If the receiver still stalls when the next result is ready, the core holds that
// result and stays busy until the register is free.
// Reset clears the sequencer and the output valid and drops any request in progress;
// s_tready stays low while reset is held, so no request is taken during it.
`include "taylor_sine_cosine_core_defines.svh"

module taylor_sine_cosine_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tsc_pkg::S_TDATA_W-1:0]  s_tdata,   // angle, then zero padding
    input  logic [0:0]                     s_tuser,   // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tsc_pkg::M_TDATA_W-1:0]  m_tdata    // value, terms_used, zero padding
);
    import tsc_pkg::*;

    state_t                   state_reg, state_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    logic [ANGLE_W-1:0]       x_reg, x_next;
    logic                     want_cos_reg, want_cos_next;
    logic [X2_W-1:0]          x2_reg, x2_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [VALUE_W-1:0]       value_reg, value_next;
    logic [TERMS_W-1:0]       terms_reg, terms_next;

    logic                     in_accept;
    logic                     out_free;
    logic                     is_last;
    logic                     div_start;
    logic                     div_done;
    logic [MAG_W-1:0]         div_quotient;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]       mul_p;
    logic [ACC_W-1:0]         acc_hi_sum;
    logic signed [SUM_W-1:0]  mag_ext;
    logic [CNT_W-1:0]         count;

    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign is_last    = (mag_reg == '0) || (iter_reg == ITER_W'(MAX_TERMS - 1));
    assign mul_p      = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign acc_hi_sum = acc_reg + (ACC_W'(mul_p) << MUL_B_W);
    assign mag_ext    = $signed({{(SUM_W - MAG_W){1'b0}}, mag_reg});
    assign count      = CNT_W'(iter_reg) + CNT_W'(2);

    tsc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_hi_sum[FRAC_W +: PROD_W]),
        .divisor  (divisor_for(iter_reg, want_cos_reg)),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SQ_LO;
            ST_SQ_LO:  state_next = ST_SQ_HI;
            ST_SQ_HI:  state_next = ST_X2;
            ST_X2:     state_next = ST_TERM;
            ST_TERM:   state_next = is_last ? ST_FIN : ST_MUL_HI;
            ST_MUL_HI: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_TERM;
            ST_FIN:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg) inside
            ST_IDLE:   s_tready = aresetn;
            ST_SQ_LO: begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = x_reg[MUL_B_W-1:0];
            end
            ST_SQ_HI: begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(x_reg[ANGLE_W-1:MUL_B_W]);
            end
            ST_TERM: begin
                mul_a = mag_reg;
                mul_b = x2_reg[MUL_B_W-1:0];
            end
            ST_MUL_HI: begin
                mul_a     = mag_reg;
                mul_b     = x2_reg[X2_W-1:MUL_B_W];
                div_start = 1'b1;
            end
            ST_X2, ST_DIV, ST_FIN: ;
            default: ;
        endcase
    end

    always_comb begin
        x_next        = x_reg;
        want_cos_next = want_cos_reg;
        x2_next       = x2_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        sum_next      = sum_reg;
        iter_next     = iter_reg;
        acc_next      = acc_reg;
        value_next    = value_reg;
        terms_next    = terms_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;

        if (in_accept) begin
            x_next        = s_tdata[ANGLE_W-1:0];
            want_cos_next = s_tuser[0];
            mag_next      = s_tuser[0] ? MAG_W'(ONE_Q30) : MAG_W'(s_tdata[ANGLE_W-1:0]);
            neg_next      = 1'b0;
            sum_next      = '0;
            iter_next     = '0;
        end

        case (state_reg) inside
            ST_SQ_LO, ST_TERM:  acc_next = ACC_W'(mul_p);
            ST_SQ_HI, ST_MUL_HI: acc_next = acc_hi_sum;
            default: ;
        endcase

        if (state_reg == ST_X2) begin
            x2_next = acc_reg[FRAC_W +: X2_W];
        end

        if (state_reg == ST_TERM) begin
            sum_next = neg_reg ? sum_reg - mag_ext : sum_reg + mag_ext;
        end

        if (state_reg == ST_DIV && div_done) begin
            mag_next  = div_quotient;
            neg_next  = !neg_reg;
            iter_next = iter_reg + ITER_W'(1);
        end

        if (state_reg == ST_FIN && out_free) begin
            m_tvalid_next = 1'b1;
            terms_next    = count[TERMS_W-1:0];
            if (sum_reg[SUM_W-1]) begin
                value_next = '0;
            end else if ($unsigned(sum_reg) > SUM_W'(ONE_Q30)) begin
                value_next = ONE_Q30;
            end else begin
                value_next = sum_reg[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        want_cos_reg <= want_cos_next;
        x2_reg       <= x2_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        sum_reg      <= sum_next;
        iter_reg     <= iter_next;
        acc_reg      <= acc_next;
        value_reg    <= value_next;
        terms_reg    <= terms_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - TERMS_W){1'b0}}, terms_reg, value_reg};

    `TSC_ASSERT_NEXT(a_accept_starts_square, in_accept, state_reg == ST_SQ_LO)
    `TSC_ASSERT_NOW(a_div_done_only_in_div, div_done, state_reg == ST_DIV)
    `TSC_ASSERT_NOW(a_no_term_past_limit, state_reg == ST_MUL_HI,
                    iter_reg != ITER_W'(MAX_TERMS - 1))
    `TSC_ASSERT_NOW(a_value_clamped, m_tvalid_reg, value_reg <= ONE_Q30)

endmodule

@@ design/tsc_divider.sv @@
// Multi-cycle unsigned divider of the term product by a small divisor, one digit a cycle.
module tsc_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tsc_pkg::PROD_W-1:0]  dividend,
    input  logic [tsc_pkg::DIV_W-1:0]   divisor,
    output logic                        done,
    output logic [tsc_pkg::MAG_W-1:0]   quotient
);
    import tsc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DIV_BITS-1:0] quo_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    dvs_reg;

    logic [DIV_BITS-1:0] quo_work;
    logic [DIV_W-1:0]    rem_work;
    logic [REM_W-1:0]    rem_wide;

    always_comb begin
        rem_work = rem_reg;
        quo_work = quo_reg;
        rem_wide = '0;
        for (int j = 0; j < DIGIT_BITS; j++) begin
            rem_wide = {rem_work, quo_work[DIV_BITS-1]};
            quo_work = {quo_work[DIV_BITS-2:0], 1'b0};
            if (rem_wide >= {1'b0, dvs_reg}) begin
                rem_wide    = rem_wide - {1'b0, dvs_reg};
                quo_work[0] = 1'b1;
            end
            rem_work = rem_wide[DIV_W-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= DIV_BITS'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_work;
            rem_reg <= rem_work;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[MAG_W-1:0];

endmodule
